/* rtl/core/mcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_pkg: shared types and constants for the MIDI channel event dispatcher
// Status nibbles, controller numbers, event kinds, field widths, reset values.
// ----------------------------------------------------------------------------
package mcd_pkg;

	localparam int NUM_CHANNELS       = 16;
	localparam int CH_IDX_W           = $clog2(NUM_CHANNELS);
	localparam int TIME_FRAC_BITS_DEF = 32;

	localparam int TIME_W  = 64;
	localparam int TICK_W  = 28;
	localparam int DUR_W   = 40;
	localparam int TPQ_W   = 16;
	localparam int TEMPO_W = 24;
	localparam int BEND_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int NIB_W   = 4;
	localparam int KIND_W  = 3;
	localparam int CFG_W   = 64;
	localparam int CFG_IDX_W = 2;
	// 1e6 * 32767 stays below 2^35
	localparam int DEN_W   = 35;

	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TPQ        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_DUR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PASS = 2'd3;

	// reset values
	localparam logic [TPQ_W-1:0]  TPQ_RST      = 16'd96;
	localparam logic [DUR_W-1:0]  TICK_DUR_RST = 40'd22369621;
	localparam logic [TIME_W-1:0] START_RST    = '0;
	localparam logic [TICK_W-1:0] PASSED_RST   = '0;

	// status high nibbles
	localparam logic [NIB_W-1:0] CMD_NOTE_OFF = 4'd8;
	localparam logic [NIB_W-1:0] CMD_NOTE_ON  = 4'd9;
	localparam logic [NIB_W-1:0] CMD_CONTROL  = 4'd11;
	localparam logic [NIB_W-1:0] CMD_PROGRAM  = 4'd12;
	localparam logic [NIB_W-1:0] CMD_PITCH    = 4'd14;
	localparam logic [NIB_W-1:0] CMD_SYSTEM   = 4'd15;

	localparam logic [NIB_W-1:0]  META_CHANNEL = 4'd15;
	localparam logic [BYTE_W-1:0] META_TEMPO   = 8'h51;
	localparam logic [NIB_W-1:0]  DRUM_CHANNEL = 4'd9;
	localparam logic [BYTE_W-1:0] DRUM_OFFSET  = 8'd128;
	localparam logic [BYTE_W-1:0] PROG_LIMIT   = 8'd128;
	localparam logic [BYTE_W-1:0] OFF_VELOCITY = 8'd64;
	localparam logic [BEND_W-1:0] BEND_CENTER  = 16'd8192;

	// controller numbers
	localparam logic [BYTE_W-1:0] CC_VOLUME     = 8'd7;
	localparam logic [BYTE_W-1:0] CC_PAN        = 8'd10;
	localparam logic [BYTE_W-1:0] CC_REVERB     = 8'd91;
	localparam logic [BYTE_W-1:0] CC_ALL_OFF_LO = 8'd123;
	localparam logic [BYTE_W-1:0] CC_ALL_OFF_HI = 8'd127;

	typedef enum logic [KIND_W-1:0] {
		EVT_VOLUME   = 3'd0,
		EVT_PAN      = 3'd1,
		EVT_REVERB   = 3'd2,
		EVT_ALL_OFF  = 3'd3,
		EVT_PROGRAM  = 3'd4,
		EVT_NOTE_ON  = 3'd5,
		EVT_NOTE_OFF = 3'd6,
		EVT_BEND     = 3'd7
	} evt_kind_t;

	// decoded event and the side effects it asks for
	typedef struct packed {
		logic              emit;
		evt_kind_t         kind;
		logic [BYTE_W-1:0] note;
		logic [BYTE_W-1:0] value;
		logic [BYTE_W-1:0] prog;
		logic [BEND_W-1:0] bend;
		logic              vol_we;
		logic              pan_we;
		logic              prog_we;
		logic              tempo;
	} mcd_evt_t;

endpackage
`default_nettype wire

/* rtl/core/mcd_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_alu: shared 64-bit add/subtract unit
// Serves tick consumption, the shift-add multiply and the restoring divide.
// ----------------------------------------------------------------------------
module mcd_alu (
	input  logic [mcd_pkg::TIME_W-1:0] a,
	input  logic [mcd_pkg::TIME_W-1:0] b,
	input  logic                       sub,
	output logic [mcd_pkg::TIME_W-1:0] sum,
	output logic                       carry
);
	import mcd_pkg::*;

	logic [TIME_W:0] full;

	// on subtract, carry high means a >= b
	assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (TIME_W+1)'(sub);
	assign sum   = full[TIME_W-1:0];
	assign carry = full[TIME_W];

endmodule
`default_nettype wire

/* rtl/core/mcd_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_decode: channel voice message decode
// Maps one latched event to the result word and the table and tempo updates.
// ----------------------------------------------------------------------------
module mcd_decode (
	input  logic [mcd_pkg::NIB_W-1:0]  cmd,
	input  logic [mcd_pkg::NIB_W-1:0]  ch,
	input  logic [mcd_pkg::BYTE_W-1:0] d1,
	input  logic [mcd_pkg::BYTE_W-1:0] d2,
	input  logic                       tpq_pos,
	input  logic [mcd_pkg::BYTE_W-1:0] chan_prog,
	output mcd_pkg::mcd_evt_t          ev
);
	import mcd_pkg::*;

	logic [BEND_W-1:0] bend_raw;

	assign bend_raw = {1'b0, d2, 7'b0} | {8'b0, d1};

	always_comb begin
		ev      = '0;
		ev.kind = EVT_VOLUME;
		unique case (cmd)
			CMD_SYSTEM: begin
				ev.tempo = (ch == META_CHANNEL) && (d1 == META_TEMPO) && tpq_pos;
			end
			CMD_CONTROL: begin
				priority if (d1 == CC_VOLUME) begin
					ev.emit   = 1'b1;
					ev.kind   = EVT_VOLUME;
					ev.value  = d2;
					ev.vol_we = 1'b1;
				end else if (d1 == CC_PAN) begin
					ev.emit   = 1'b1;
					ev.kind   = EVT_PAN;
					ev.value  = d2;
					ev.pan_we = 1'b1;
				end else if (d1 == CC_REVERB) begin
					ev.emit  = 1'b1;
					ev.kind  = EVT_REVERB;
					ev.value = d2;
				end else if ((d1 >= CC_ALL_OFF_LO) && (d1 <= CC_ALL_OFF_HI)) begin
					ev.emit = 1'b1;
					ev.kind = EVT_ALL_OFF;
				end else begin
					ev.emit = 1'b0;
				end
			end
			CMD_PROGRAM: begin
				if (d1 < PROG_LIMIT) begin
					ev.emit    = 1'b1;
					ev.kind    = EVT_PROGRAM;
					ev.value   = d1;
					ev.prog_we = 1'b1;
				end
			end
			CMD_NOTE_ON: begin
				ev.emit = 1'b1;
				ev.note = d1;
				if (d2 != '0) begin
					ev.kind  = EVT_NOTE_ON;
					ev.value = d2;
					ev.prog  = (ch == DRUM_CHANNEL) ? (d1 + DRUM_OFFSET) : chan_prog;
				end else begin
					// zero velocity: note off at middle velocity
					ev.kind  = EVT_NOTE_OFF;
					ev.value = OFF_VELOCITY;
				end
			end
			CMD_NOTE_OFF: begin
				ev.emit  = 1'b1;
				ev.kind  = EVT_NOTE_OFF;
				ev.note  = d1;
				ev.value = d2;
			end
			CMD_PITCH: begin
				ev.emit = 1'b1;
				ev.kind = EVT_BEND;
				ev.bend = bend_raw - BEND_CENTER;
			end
			default: begin
				ev.emit = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/midi_channel_event_dispatch_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_channel_event_dispatch_top: MIDI track event to channel event dispatcher
// Advances a Q32.32 track clock and turns channel voice messages into events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one decoded track event word:
//   delta ticks, status nibbles, two data bytes and the tempo meta payload.
//   Output channel (out_valid / out_stall) gives zero or one event word per
//   input word, stamped with the track time after the delta is applied.
//   One word is in flight at a time; in_stall is high while it is worked on.
//   Steps per word: accept, tick consumption (ST_CONS_A, then ST_CONS_B when
//   the delta exceeds the pending ticks), shift-add multiply over the bits of
//   the leftover ticks, dispatch and output load. A tempo meta word goes from
//   dispatch to the restoring divider, one quotient bit per dividend bit.
//   Tick consumption, multiply and divide share one 64-bit add/subtract unit.
//   The output register decouples the sides: a new word is accepted while an
//   event still waits; the next event holds in the dispatch path until the
//   receiver drops out_stall.
//   Reset loads the track clock, tick duration and pending ticks from register
//   defaults and clears the channel tables. The user must send configuration
//   writes through the cfg port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module midi_channel_event_dispatch_top #(
	parameter int TIME_FRAC_BITS = mcd_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [mcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcd_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mcd_pkg::TICK_W-1:0]    delta_ticks,
	input  logic [mcd_pkg::NIB_W-1:0]     command,
	input  logic [mcd_pkg::NIB_W-1:0]     channel,
	input  logic [mcd_pkg::BYTE_W-1:0]    data_first,
	input  logic [mcd_pkg::BYTE_W-1:0]    data_second,
	input  logic [mcd_pkg::TEMPO_W-1:0]   tempo_value,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mcd_pkg::KIND_W-1:0]    event_kind,
	output logic [mcd_pkg::TIME_W-1:0]    event_time,
	output logic [mcd_pkg::NIB_W-1:0]     out_channel,
	output logic [mcd_pkg::BYTE_W-1:0]    note_number,
	output logic [mcd_pkg::BYTE_W-1:0]    event_value,
	output logic [mcd_pkg::BYTE_W-1:0]    note_program,
	output logic signed [mcd_pkg::BEND_W-1:0] bend_amount
);
	import mcd_pkg::*;

	// dividend bits walked by the divider, and its counter
	localparam int DVD_W = TEMPO_W + TIME_FRAC_BITS;
	localparam int CNT_W = $clog2(DVD_W);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_CONS_A   = 7'b0000010,
		ST_CONS_B   = 7'b0000100,
		ST_MUL      = 7'b0001000,
		ST_DISPATCH = 7'b0010000,
		ST_DIV      = 7'b0100000,
		ST_EMIT     = 7'b1000000
	} st_t;

	st_t state_q;

	// architectural state
	logic [TIME_W-1:0] current_time_q;
	logic [DUR_W-1:0]  tick_dur_q;
	logic [TICK_W-1:0] pending_q;
	logic [TPQ_W-1:0]  tpq_q;
	logic [BYTE_W-1:0] prog_tbl_q [NUM_CHANNELS];
	logic [BYTE_W-1:0] vol_tbl_q  [NUM_CHANNELS];
	logic [BYTE_W-1:0] pan_tbl_q  [NUM_CHANNELS];

	// latched input word
	logic [TICK_W-1:0]  delta_q;
	logic [NIB_W-1:0]   cmd_q;
	logic [NIB_W-1:0]   ch_q;
	logic [BYTE_W-1:0]  d1_q;
	logic [BYTE_W-1:0]  d2_q;
	logic [TEMPO_W-1:0] tempo_q;

	// sequencer working registers
	logic [TICK_W-1:0] mplier_q;   // leftover ticks, shifted right per step
	logic [TIME_W-1:0] mcand_q;    // multiplicand, reused as divider dividend
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	mcd_evt_t          ev_q;

	// output register
	logic              out_valid_q;
	evt_kind_t         out_kind_q;
	logic [TIME_W-1:0] out_time_q;
	logic [NIB_W-1:0]  out_ch_q;
	logic [BYTE_W-1:0] out_note_q;
	logic [BYTE_W-1:0] out_value_q;
	logic [BYTE_W-1:0] out_prog_q;
	logic [BEND_W-1:0] out_bend_q;

	logic [TIME_W-1:0] alu_a;
	logic [TIME_W-1:0] alu_b;
	logic              alu_sub;
	logic [TIME_W-1:0] alu_sum;
	logic              alu_carry;
	logic [DEN_W:0]    trial;
	logic              tpq_pos;
	logic [CH_IDX_W-1:0] ch_idx;
	mcd_evt_t          ev;
	logic              in_take;
	logic              out_take;
	logic              out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	assign tpq_pos = !tpq_q[TPQ_W-1] && (tpq_q != '0);
	assign ch_idx  = ch_q[CH_IDX_W-1:0];
	// next partial remainder: shift in the top dividend bit
	assign trial   = {rem_q, mcand_q[TIME_W-1]};

	// operand select for the shared unit
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_CONS_A: begin
				alu_a   = TIME_W'(pending_q);
				alu_b   = TIME_W'(delta_q);
				alu_sub = 1'b1;
			end
			ST_CONS_B: begin
				alu_a   = TIME_W'(delta_q);
				alu_b   = TIME_W'(pending_q);
				alu_sub = 1'b1;
			end
			ST_MUL: begin
				alu_a = current_time_q;
				alu_b = mcand_q;
			end
			ST_DIV: begin
				alu_a   = TIME_W'(trial);
				alu_b   = TIME_W'(den_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	mcd_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	mcd_decode u_decode (
		.cmd       (cmd_q),
		.ch        (ch_q),
		.d1        (d1_q),
		.d2        (d2_q),
		.tpq_pos   (tpq_pos),
		.chan_prog (prog_tbl_q[ch_idx]),
		.ev        (ev)
	);

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			current_time_q <= START_RST;
			tick_dur_q     <= TICK_DUR_RST;
			pending_q      <= PASSED_RST;
			tpq_q          <= TPQ_RST;
			mplier_q       <= '0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				prog_tbl_q[i] <= '0;
				vol_tbl_q[i]  <= '0;
				pan_tbl_q[i]  <= '0;
			end
		end else begin
			// a fresh load wins over the release of the word just taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_CONS_A;
					end
				end
				ST_CONS_A: begin
					// pending >= delta: use up the delta from pending ticks
					if (alu_carry) begin
						pending_q <= alu_sum[TICK_W-1:0];
						mplier_q  <= '0;
						state_q   <= ST_MUL;
					end else begin
						state_q <= ST_CONS_B;
					end
				end
				ST_CONS_B: begin
					mplier_q  <= alu_sum[TICK_W-1:0];
					pending_q <= '0;
					state_q   <= ST_MUL;
				end
				ST_MUL: begin
					if (mplier_q == '0) begin
						state_q <= ST_DISPATCH;
					end else begin
						if (mplier_q[0]) begin
							current_time_q <= alu_sum;
						end
						mplier_q <= mplier_q >> 1;
					end
				end
				ST_DISPATCH: begin
					if (ev.vol_we) begin
						vol_tbl_q[ch_idx] <= d2_q;
					end
					if (ev.pan_we) begin
						pan_tbl_q[ch_idx] <= d2_q;
					end
					if (ev.prog_we) begin
						prog_tbl_q[ch_idx] <= d1_q;
					end
					priority if (ev.tempo) begin
						cnt_q   <= CNT_W'(DVD_W - 1);
						state_q <= ST_DIV;
					end else if (ev.emit) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					// quotient bits shift straight into the tick duration
					tick_dur_q <= {tick_dur_q[DUR_W-2:0], alu_carry};
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TPQ:        tpq_q          <= cfg_data[TPQ_W-1:0];
					REG_TICK_DUR:   tick_dur_q     <= cfg_data[DUR_W-1:0];
					REG_START_TIME: current_time_q <= cfg_data[TIME_W-1:0];
					REG_TICKS_PASS: pending_q      <= cfg_data[TICK_W-1:0];
					default:        tpq_q          <= tpq_q;
				endcase
			end
		end
	end

	// payload registers: input latch, multiplicand/dividend, remainder, output
	always_ff @(posedge clk) begin
		if (in_take) begin
			delta_q <= delta_ticks;
			cmd_q   <= command;
			ch_q    <= channel;
			d1_q    <= data_first;
			d2_q    <= data_second;
			tempo_q <= tempo_value;
		end
		unique case (state_q)
			ST_CONS_A: begin
				mcand_q <= TIME_W'(tick_dur_q);
			end
			ST_MUL: begin
				mcand_q <= mcand_q << 1;
			end
			ST_DISPATCH: begin
				ev_q    <= ev;
				// left-align the dividend so its top bit is always bit 63
				mcand_q <= {tempo_q, {(TIME_W - TEMPO_W){1'b0}}};
				den_q   <= DEN_W'(USEC_PER_SEC) * DEN_W'(tpq_q[TPQ_W-2:0]);
				rem_q   <= '0;
			end
			ST_DIV: begin
				mcand_q <= mcand_q << 1;
				rem_q   <= alu_carry ? alu_sum[DEN_W-1:0] : trial[DEN_W-1:0];
			end
			default: begin
				mcand_q <= mcand_q;
			end
		endcase
		if (out_load) begin
			out_kind_q  <= ev_q.kind;
			out_time_q  <= current_time_q;
			out_ch_q    <= ch_q;
			out_note_q  <= ev_q.note;
			out_value_q <= ev_q.value;
			out_prog_q  <= ev_q.prog;
			out_bend_q  <= ev_q.bend;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = out_kind_q;
	assign event_time   = out_time_q;
	assign out_channel  = out_ch_q;
	assign note_number  = out_note_q;
	assign event_value  = out_value_q;
	assign note_program = out_prog_q;
	assign bend_amount  = out_bend_q;

endmodule
`default_nettype wire

/* rtl/core/mcd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_checker: port-level checks for the MIDI channel event dispatcher
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
module mcd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [mcd_pkg::TICK_W-1:0]    delta_ticks,
	input  logic [mcd_pkg::NIB_W-1:0]     command,
	input  logic [mcd_pkg::NIB_W-1:0]     channel,
	input  logic [mcd_pkg::BYTE_W-1:0]    data_first,
	input  logic [mcd_pkg::BYTE_W-1:0]    data_second,
	input  logic [mcd_pkg::TEMPO_W-1:0]   tempo_value,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [mcd_pkg::KIND_W-1:0]    event_kind,
	input  logic [mcd_pkg::TIME_W-1:0]    event_time,
	input  logic [mcd_pkg::NIB_W-1:0]     out_channel,
	input  logic [mcd_pkg::BYTE_W-1:0]    note_number,
	input  logic [mcd_pkg::BYTE_W-1:0]    event_value,
	input  logic [mcd_pkg::BYTE_W-1:0]    note_program,
	input  logic signed [mcd_pkg::BEND_W-1:0] bend_amount
);
	import mcd_pkg::*;

	// an accepted word keeps the input side busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted back to back");

	// a stalled event word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_time)
			&& $stable(event_kind) && $stable(out_channel))
		else $error("stalled event word changed");

	// drum channel note on carries the remapped drum id
	a_drum_remap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EVT_NOTE_ON) && (out_channel == DRUM_CHANNEL)
			|-> note_program == (note_number + DRUM_OFFSET))
		else $error("drum program remap wrong");

	// only pitch bend words carry a bend amount, only note on a program
	a_field_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_kind == EVT_BEND) || (bend_amount == '0))
			&& ((event_kind == EVT_NOTE_ON) || (note_program == '0)))
		else $error("unused event field not zero");

endmodule

bind midi_channel_event_dispatch_top mcd_checker u_mcd_checker (.*);
`default_nettype wire

/* test/channel_event_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_event_checker: event predictor and scoreboard for the dispatcher
// Mirrors track clock, tick duration, pending ticks and channel programs,
// predicts the event of each accepted track word and checks the output words.
// ----------------------------------------------------------------------------
module channel_event_checker
	import mcd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [TICK_W-1:0]    delta_ticks,
	input  logic [NIB_W-1:0]     command,
	input  logic [NIB_W-1:0]     channel,
	input  logic [BYTE_W-1:0]    data_first,
	input  logic [BYTE_W-1:0]    data_second,
	input  logic [TEMPO_W-1:0]   tempo_value,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [KIND_W-1:0]    event_kind,
	input  logic [TIME_W-1:0]    event_time,
	input  logic [NIB_W-1:0]     out_channel,
	input  logic [BYTE_W-1:0]    note_number,
	input  logic [BYTE_W-1:0]    event_value,
	input  logic [BYTE_W-1:0]    note_program,
	input  logic signed [BEND_W-1:0] bend_amount,
	output int                   fail_count,
	output int                   outstanding
);

	localparam int MAX_REPORTS   = 10;
	localparam int BEND_MSB_SHIFT = 7;

	typedef struct packed {
		evt_kind_t         kind;
		logic [TIME_W-1:0] stamp;
		logic [NIB_W-1:0]  chan;
		logic [BYTE_W-1:0] note;
		logic [BYTE_W-1:0] value;
		logic [BYTE_W-1:0] prog;
		logic [BEND_W-1:0] bend;
	} chan_event_t;

	logic signed [TPQ_W-1:0] division;
	logic [TIME_W-1:0]       track_time;
	logic [DUR_W-1:0]        tick_len;
	logic [TICK_W-1:0]       ticks_owed;
	logic [BYTE_W-1:0]       programs [NUM_CHANNELS];
	chan_event_t             predicted_events [$];
	int                      mismatches;

	// advance the track clock for one word and work out the event it gives
	function automatic bit dispatch_event(
		input  logic [TICK_W-1:0]  delay,
		input  logic [NIB_W-1:0]   cmd,
		input  logic [NIB_W-1:0]   ch,
		input  logic [BYTE_W-1:0]  d1,
		input  logic [BYTE_W-1:0]  d2,
		input  logic [TEMPO_W-1:0] tempo,
		output chan_event_t        ev
	);
		logic [TICK_W-1:0] left;
		logic [TIME_W-1:0] num;
		logic [TIME_W-1:0] den;
		logic [BEND_W-1:0] raw;
		bit                hit;
		if (delay > ticks_owed) begin
			left       = delay - ticks_owed;
			ticks_owed = '0;
		end else begin
			ticks_owed = ticks_owed - delay;
			left       = '0;
		end
		track_time = track_time + TIME_W'(left) * TIME_W'(tick_len);
		ev       = '0;
		ev.stamp = track_time;
		ev.chan  = ch;
		hit      = 1'b0;
		case (cmd)
			CMD_SYSTEM: begin
				if (ch == META_CHANNEL && d1 == META_TEMPO && division > 0) begin
					num      = TIME_W'(tempo) << TIME_FRAC_BITS_DEF;
					den      = TIME_W'(USEC_PER_SEC) * TIME_W'(division);
					tick_len = DUR_W'(num / den);
				end
			end
			CMD_CONTROL: begin
				hit = 1'b1;
				if (d1 == CC_VOLUME) begin
					ev.kind  = EVT_VOLUME;
					ev.value = d2;
				end else if (d1 == CC_PAN) begin
					ev.kind  = EVT_PAN;
					ev.value = d2;
				end else if (d1 == CC_REVERB) begin
					ev.kind  = EVT_REVERB;
					ev.value = d2;
				end else if (d1 >= CC_ALL_OFF_LO && d1 <= CC_ALL_OFF_HI) begin
					ev.kind = EVT_ALL_OFF;
				end else begin
					hit = 1'b0;
				end
			end
			CMD_PROGRAM: begin
				if (d1 < PROG_LIMIT) begin
					programs[ch] = d1;
					ev.kind      = EVT_PROGRAM;
					ev.value     = d1;
					hit          = 1'b1;
				end
			end
			CMD_NOTE_ON, CMD_NOTE_OFF: begin
				hit     = 1'b1;
				ev.note = d1;
				if (cmd == CMD_NOTE_ON && d2 != '0) begin
					ev.kind  = EVT_NOTE_ON;
					ev.value = d2;
					ev.prog  = (ch == DRUM_CHANNEL) ? d1 + DRUM_OFFSET : programs[ch];
				end else begin
					ev.kind  = EVT_NOTE_OFF;
					ev.value = (cmd == CMD_NOTE_ON) ? OFF_VELOCITY : d2;
				end
			end
			CMD_PITCH: begin
				raw     = (BEND_W'(d2) << BEND_MSB_SHIFT) | BEND_W'(d1);
				ev.kind = EVT_BEND;
				ev.bend = raw - BEND_CENTER;
				hit     = 1'b1;
			end
			default: ;
		endcase
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chan_event_t ev;
		chan_event_t want;
		if (!arst_n) begin
			division   = TPQ_RST;
			tick_len   = TICK_DUR_RST;
			track_time = START_RST;
			ticks_owed = PASSED_RST;
			foreach (programs[i]) programs[i] = '0;
			predicted_events.delete();
			mismatches = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TPQ:        division   = cfg_data[TPQ_W-1:0];
					REG_TICK_DUR:   tick_len   = cfg_data[DUR_W-1:0];
					REG_START_TIME: track_time = cfg_data;
					REG_TICKS_PASS: ticks_owed = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			// retire the output word first: it always belongs to an older track word
			if (out_valid && !out_stall) begin
				if (predicted_events.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected event kind %0d time %h ch %0d", $realtime,
							event_kind, event_time, out_channel);
				end else begin
					want = predicted_events.pop_front();
					if (want.kind !== event_kind || want.stamp !== event_time ||
						want.chan !== out_channel || want.note !== note_number ||
						want.value !== event_value || want.prog !== note_program ||
						want.bend !== bend_amount) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: expected kind %0d time %h ch %0d note %0d val %0d prog %0d bend %0d",
								$realtime, want.kind, want.stamp, want.chan, want.note,
								want.value, want.prog, $signed(want.bend));
							$display("%0t: actual   kind %0d time %h ch %0d note %0d val %0d prog %0d bend %0d",
								$realtime, event_kind, event_time, out_channel, note_number,
								event_value, note_program, bend_amount);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (dispatch_event(delta_ticks, command, channel, data_first, data_second,
					tempo_value, ev))
					predicted_events.push_back(ev);
			end
			fail_count  <= mismatches;
			outstanding <= predicted_events.size();
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the MIDI channel event dispatcher
// Drives directed and random track words under several register settings,
// with random idling on both channels and one long output hold-off. The
// checker instance predicts every event and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
	import mcd_pkg::*;

	localparam int CLK_HIGH     = 4;
	localparam int CLK_LOW      = 4;
	localparam int RESET_CYCLES = 3;
	// longest silent word is a tempo divide
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_PCT     = 25;
	localparam int NUM_PHASES   = 5;
	localparam int PHASE_WORDS  = 160;
	localparam int TIMEOUT_NS   = 5_000_000;

	// status nibbles and bytes the block does not act on, and a 120 BPM tempo
	localparam logic [NIB_W-1:0]  CMD_DATA_MIN      = 4'd0;
	localparam logic [NIB_W-1:0]  CMD_DATA_MAX      = 4'd7;
	localparam logic [NIB_W-1:0]  CMD_POLY_PRESSURE = 4'd10;
	localparam logic [NIB_W-1:0]  CMD_CHAN_PRESSURE = 4'd13;
	localparam logic [BYTE_W-1:0] CC_LOCAL_CTRL     = 8'd122;
	localparam logic [BYTE_W-1:0] META_END_TRACK    = 8'h2F;
	localparam logic [TEMPO_W-1:0] TEMPO_120BPM     = 24'd500000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [TICK_W-1:0]    delta_ticks;
	logic [NIB_W-1:0]     command;
	logic [NIB_W-1:0]     channel;
	logic [BYTE_W-1:0]    data_first;
	logic [BYTE_W-1:0]    data_second;
	logic [TEMPO_W-1:0]   tempo_value;
	logic                 out_valid;
	logic                 out_stall;
	logic [KIND_W-1:0]    event_kind;
	logic [TIME_W-1:0]    event_time;
	logic [NIB_W-1:0]     out_channel;
	logic [BYTE_W-1:0]    note_number;
	logic [BYTE_W-1:0]    event_value;
	logic [BYTE_W-1:0]    note_program;
	logic signed [BEND_W-1:0] bend_amount;
	int                   fail_count;
	int                   outstanding;

	// traffic shaping flags shared by the sender and the receiver
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;

	midi_channel_event_dispatch_top i_dut (.*);

	channel_event_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#(CLK_LOW);
		clk = 1'b1;
		#(CLK_HIGH);
	end

	// Offer one track word after an optional random gap; hold it until taken.
	task automatic send_word(
		input logic [TICK_W-1:0]  delay,
		input logic [NIB_W-1:0]   cmd,
		input logic [NIB_W-1:0]   ch,
		input logic [BYTE_W-1:0]  d1,
		input logic [BYTE_W-1:0]  d2,
		input logic [TEMPO_W-1:0] tempo
	);
		while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		delta_ticks <= delay;
		command     <= cmd;
		channel     <= ch;
		data_first  <= d1;
		data_second <= d2;
		tempo_value <= tempo;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Mostly well-formed voice and tempo words, with some raw noise mixed in.
	task automatic send_random_word();
		logic [TICK_W-1:0]  delay;
		logic [NIB_W-1:0]   cmd;
		logic [NIB_W-1:0]   ch;
		logic [BYTE_W-1:0]  d1;
		logic [BYTE_W-1:0]  d2;
		logic [TEMPO_W-1:0] tempo;
		int                 span;
		int                 pick;
		// keep most deltas short so the multiplier stays quick; some use all bits
		span = $urandom_range(15);
		if (span < 8)
			delay = TICK_W'($urandom_range(7));
		else if (span < 13)
			delay = TICK_W'($urandom_range(255));
		else if (span < 15)
			delay = TICK_W'($urandom_range(65535));
		else
			delay = TICK_W'($urandom);
		ch = NIB_W'($urandom_range(NUM_CHANNELS - 1));
		if ($urandom_range(9) == 0) ch = DRUM_CHANNEL;
		d1    = BYTE_W'($urandom_range(255));
		d2    = BYTE_W'($urandom_range(255));
		tempo = TEMPO_W'($urandom_range(24'hFFFFFF));
		pick  = $urandom_range(99);
		if (pick < 20) begin
			cmd = CMD_NOTE_ON;
			if ($urandom_range(6) == 0) d2 = '0;
		end else if (pick < 32) begin
			cmd = CMD_NOTE_OFF;
		end else if (pick < 55) begin
			cmd = CMD_CONTROL;
			case ($urandom_range(5))
				0: d1 = CC_VOLUME;
				1: d1 = CC_PAN;
				2: d1 = CC_REVERB;
				3: d1 = BYTE_W'($urandom_range(CC_ALL_OFF_HI, CC_ALL_OFF_LO));
				default: ;
			endcase
		end else if (pick < 67) begin
			cmd = CMD_PROGRAM;
		end else if (pick < 77) begin
			cmd = CMD_PITCH;
		end else if (pick < 88) begin
			cmd = CMD_SYSTEM;
			if ($urandom_range(9) < 7) begin
				ch = META_CHANNEL;
				d1 = META_TEMPO;
			end
			// musical tempos half the time, raw payloads otherwise
			if ($urandom_range(1) == 1) tempo = TEMPO_W'($urandom_range(2_000_000, 100_000));
		end else begin
			cmd = NIB_W'($urandom_range(15));
		end
		send_word(delay, cmd, ch, d1, d2, tempo);
	endtask

	// Write all four registers back to back; the block must be idle.
	task automatic load_regs(
		input logic [TPQ_W-1:0]  tpq,
		input logic [DUR_W-1:0]  dur,
		input logic [TIME_W-1:0] start,
		input logic [TICK_W-1:0] passed
	);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TPQ;
		cfg_data  <= CFG_W'(tpq);
		@(posedge clk);
		cfg_index <= REG_TICK_DUR;
		cfg_data  <= CFG_W'(dur);
		@(posedge clk);
		cfg_index <= REG_START_TIME;
		cfg_data  <= CFG_W'(start);
		@(posedge clk);
		cfg_index <= REG_TICKS_PASS;
		cfg_data  <= CFG_W'(passed);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for every predicted event, then let a silent word finish too.
	task automatic drain_events();
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stalls, one long hold-off to back the block up,
	// and a quiet stretch with no stalls at all.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (rx_steady) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_TPQ;
		cfg_data    = '0;
		in_valid    = 1'b0;
		delta_ticks = '0;
		command     = CMD_DATA_MIN;
		channel     = '0;
		data_first  = '0;
		data_second = '0;
		tempo_value = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset defaults
		send_word('0, CMD_NOTE_ON, 4'd0, 8'd60, 8'd100, '0);
		send_word('1, CMD_NOTE_OFF, 4'd15, 8'hFF, 8'hFF, '1);
		send_word(28'd5, CMD_PROGRAM, 4'd3, 8'd127, 8'd0, '0);
		// program of channel 3 shows up on its note on
		send_word(28'd1, CMD_NOTE_ON, 4'd3, 8'd0, 8'd127, '0);
		// drum note id wraps past 255
		send_word(28'd2, CMD_NOTE_ON, DRUM_CHANNEL, 8'd200, 8'd1, '0);
		// zero velocity note on turns into a note off
		send_word('0, CMD_NOTE_ON, 4'd4, 8'd64, 8'd0, '0);
		send_word(28'd3, CMD_CONTROL, 4'd1, CC_VOLUME, 8'hFF, '0);
		send_word(28'd1, CMD_CONTROL, 4'd2, CC_PAN, 8'd0, '0);
		send_word(28'd1, CMD_CONTROL, 4'd5, CC_REVERB, 8'd128, '0);
		send_word('0, CMD_CONTROL, 4'd6, CC_ALL_OFF_LO, 8'd9, '0);
		send_word('0, CMD_CONTROL, 4'd7, CC_ALL_OFF_HI, 8'd9, '0);
		// controllers outside the decoded set give nothing
		send_word(28'd4, CMD_CONTROL, 4'd8, CC_LOCAL_CTRL, 8'd1, '0);
		send_word(28'd4, CMD_CONTROL, 4'd8, CC_ALL_OFF_HI + 8'd1, 8'd1, '0);
		send_word(28'd2, CMD_PROGRAM, 4'd3, PROG_LIMIT, 8'd0, '0);
		// bend extremes and center
		send_word(28'd1, CMD_PITCH, 4'd10, 8'd0, 8'd0, '0);
		send_word(28'd1, CMD_PITCH, 4'd11, 8'hFF, 8'hFF, '0);
		send_word(28'd1, CMD_PITCH, 4'd12, 8'd0, 8'd64, '0);
		// tempo changes, then a note to show the new tick length
		send_word(28'd10, CMD_SYSTEM, META_CHANNEL, META_TEMPO, 8'd0, TEMPO_120BPM);
		send_word(28'd96, CMD_NOTE_ON, 4'd13, 8'd72, 8'd90, '0);
		send_word(28'd1, CMD_SYSTEM, META_CHANNEL, META_TEMPO, 8'd0, '1);
		send_word(28'd1, CMD_SYSTEM, META_CHANNEL, META_END_TRACK, 8'd0, '0);
		send_word(28'd1, CMD_SYSTEM, 4'd0, META_TEMPO, 8'd0, TEMPO_120BPM);
		// data-range and pressure nibbles move the clock only
		send_word(28'd7, CMD_DATA_MIN, 4'd0, 8'd1, 8'd1, '0);
		send_word(28'd7, CMD_POLY_PRESSURE, 4'd1, 8'd1, 8'd1, '0);
		send_word(28'd7, CMD_CHAN_PRESSURE, 4'd2, 8'd1, 8'd1, '0);
		send_word(28'd7, CMD_DATA_MAX, 4'd3, 8'd1, 8'd1, '0);
		send_word(28'd1, CMD_NOTE_OFF, 4'd14, 8'd72, 8'd33, '0);
		in_valid <= 1'b0;

		// Random traffic, one register setting per phase
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain_events();
			case (phase)
				0: load_regs(16'h7FFF, '0, '1, '1);
				1: load_regs(16'h8000, '1, '0, '0);
				2: load_regs(16'd1, DUR_W'({$urandom, $urandom}), {$urandom, $urandom},
					TICK_W'($urandom_range(1000)));
				3: load_regs('0, DUR_W'($urandom), {$urandom, $urandom}, TICK_W'(300));
				default: load_regs(16'd480, TICK_DUR_RST, START_RST, PASSED_RST);
			endcase
			// back up the output once, and run one phase with no idling
			if (phase == 1) hold_req = 1'b1;
			tx_steady = (phase == 2);
			rx_steady = (phase == 2);
			repeat (PHASE_WORDS) send_random_word();
			in_valid <= 1'b0;
		end

		drain_events();
		if (fail_count == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
